FILE: rtl/core/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg
// Shared widths, limits and types of the Fenwick-tree inversion counter.
// ----------------------------------------------------------------------------
package fic_pkg;

  localparam int VALUE_W      = 16;
  localparam int COUNT_W      = 32;
  localparam int TOTAL_W      = 48;
  localparam int SIZE_DEFAULT = 65535;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // finished item, handed from the sequencer to the output stage
  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
    logic               bad;
  } fic_result_t;

endpackage

FILE: rtl/core/fic_ram.sv
// ----------------------------------------------------------------------------
// fic_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/fic_ctrl.sv
// ----------------------------------------------------------------------------
// fic_ctrl
// Tree sequencer: clearing pass, prefix query walk and update walk over the
// node memory.
// ----------------------------------------------------------------------------
module fic_ctrl #(
  parameter int SIZE = fic_pkg::SIZE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  output logic                         value_ready,
  input  logic [fic_pkg::VALUE_W-1:0]  value,
  output fic_pkg::fic_result_t         result,
  input  logic                         result_free
);

  localparam int IDX_W = $clog2(SIZE + 1);
  localparam int PW    = IDX_W + 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_QUERY  = 3'd2;
  localparam logic [2:0] S_QDRAIN = 3'd3;
  localparam logic [2:0] S_UREAD  = 3'd4;
  localparam logic [2:0] S_UWRITE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                    state;
  logic [IDX_W-1:0]              clr_cnt;
  logic [PW-1:0]                 pos;
  logic [PW-1:0]                 vpos;
  logic                          rd_pend;
  logic [fic_pkg::COUNT_W-1:0]   acc;
  logic                          bad;

  logic [PW-1:0]                 low_bit;
  logic [PW-1:0]                 pos_down;
  logic [PW-1:0]                 pos_up;
  logic [fic_pkg::COUNT_W:0]     acc_sum;
  logic [fic_pkg::COUNT_W-1:0]   acc_next;
  logic                          in_bad;

  logic [IDX_W-1:0]              ram_addr;
  logic                          ram_we;
  logic [fic_pkg::COUNT_W-1:0]   ram_wdata;
  logic [fic_pkg::COUNT_W-1:0]   ram_rdata;

  fic_ram #(
    .WIDTH (fic_pkg::COUNT_W),
    .DEPTH (SIZE + 1)
  ) u_nodes (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign low_bit  = pos & (~pos + PW'(1));
  assign pos_down = pos - low_bit;
  assign pos_up   = pos + low_bit;

  assign acc_sum  = {1'b0, acc} + {1'b0, ram_rdata};
  assign acc_next = acc_sum[fic_pkg::COUNT_W] ? fic_pkg::COUNT_MAX
                                              : acc_sum[fic_pkg::COUNT_W-1:0];

  assign in_bad = (value == '0) || (32'(value) > 32'(SIZE));

  assign value_ready = (state == S_IDLE);

  assign result.valid = (state == S_DONE);
  assign result.count = acc;
  assign result.bad   = bad;

  always_comb begin
    ram_addr  = pos[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_wdata = (ram_rdata == fic_pkg::COUNT_MAX) ? fic_pkg::COUNT_MAX
                                                  : ram_rdata + 1'b1;
    case (state)
      S_CLEAR: begin
        ram_addr  = clr_cnt;
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_UWRITE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(SIZE)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (value_valid) begin
            acc  <= '0;
            bad  <= in_bad;
            pos  <= PW'(value);
            vpos <= PW'(value);
            state <= in_bad ? S_DONE : S_QUERY;
          end
        end
        S_QUERY: begin
          if (rd_pend) begin
            acc <= acc_next;
          end
          rd_pend <= 1'b1;
          pos     <= pos_down;
          if (pos_down == '0) begin
            state <= S_QDRAIN;
          end
        end
        S_QDRAIN: begin
          acc     <= acc_next;
          rd_pend <= 1'b0;
          pos     <= vpos;
          state   <= S_UREAD;
        end
        S_UREAD: begin
          state <= S_UWRITE;
        end
        S_UWRITE: begin
          pos <= pos_up;
          state <= (pos_up > PW'(SIZE)) ? S_DONE : S_UREAD;
        end
        S_DONE: begin
          if (result_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/fic_out.sv
// ----------------------------------------------------------------------------
// fic_out
// Running total and output word register.
// ----------------------------------------------------------------------------
module fic_out (
  input  logic                         clk,
  input  logic                         rst,
  input  fic_pkg::fic_result_t         result,
  output logic                         result_free,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [fic_pkg::COUNT_W-1:0]  smaller_count,
  output logic [fic_pkg::TOTAL_W-1:0]  running_total,
  output logic                         bad_value
);

  logic [fic_pkg::TOTAL_W-1:0] total;
  logic [fic_pkg::TOTAL_W:0]   total_sum;
  logic [fic_pkg::TOTAL_W-1:0] total_next;

  assign result_free = !result_valid || result_ready;

  // bad words carry a zero count, so the total stays put
  assign total_sum  = {1'b0, total} + (fic_pkg::TOTAL_W + 1)'(result.count);
  assign total_next = total_sum[fic_pkg::TOTAL_W] ? fic_pkg::TOTAL_MAX
                                                  : total_sum[fic_pkg::TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (result.valid && result_free) begin
        total         <= total_next;
        result_valid  <= 1'b1;
        smaller_count <= result.count;
        running_total <= total_next;
        bad_value     <= result.bad;
      end
    end
  end

endmodule

FILE: rtl/core/fenwick_inversion_counter.sv
// ----------------------------------------------------------------------------
// fenwick_inversion_counter
// Counts inversions in a stream with a binary indexed tree held in one
// single-port node memory.
//
//   channel   signals                      word
//   input     value_valid / value_ready    value
//   output    result_valid / result_ready  smaller_count, running_total,
//                                          bad_value
//
// A valid value makes one memory read per query node and a read and a write
// per update node, all through the single node memory port.
// After reset a clearing pass writes zero to all SIZE + 1 nodes, one a cycle,
// with value_ready low.
// A result waits in the output register while the next value is taken in.
// ----------------------------------------------------------------------------
module fenwick_inversion_counter #(
  parameter int SIZE = fic_pkg::SIZE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  output logic                         value_ready,
  input  logic [fic_pkg::VALUE_W-1:0]  value,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [fic_pkg::COUNT_W-1:0]  smaller_count,
  output logic [fic_pkg::TOTAL_W-1:0]  running_total,
  output logic                         bad_value
);

  fic_pkg::fic_result_t result;
  logic                 result_free;

  fic_ctrl #(
    .SIZE (SIZE)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .result      (result),
    .result_free (result_free)
  );

  fic_out u_out (
    .clk           (clk),
    .rst           (rst),
    .result        (result),
    .result_free   (result_free),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .smaller_count (smaller_count),
    .running_total (running_total),
    .bad_value     (bad_value)
  );

endmodule

FILE: rtl/core/fic_checker.sv
// ----------------------------------------------------------------------------
// fic_checker
// Port-level checks on the inversion counter, bound to the top level.
// ----------------------------------------------------------------------------
module fic_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         value_valid,
  input logic                         value_ready,
  input logic [fic_pkg::VALUE_W-1:0]  value,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [fic_pkg::COUNT_W-1:0]  smaller_count,
  input logic [fic_pkg::TOTAL_W-1:0]  running_total,
  input logic                         bad_value
);

  // stalled output word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(smaller_count) && $stable(running_total)
      && $stable(bad_value))
    else $error("stalled result word changed");

  // offered input word holds until taken
  a_value_hold: assert property (@(posedge clk) disable iff (rst)
    value_valid && !value_ready |=> value_valid && $stable(value))
    else $error("offered input word dropped or changed");

  // a bad value never reports a count
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_value |-> smaller_count == '0)
    else $error("bad value with nonzero count");

  // node memory clear keeps the input closed
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !value_ready)
    else $error("input open during clear");

  // one word in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    value_valid && value_ready |=> !value_ready)
    else $error("input open right after a word was taken");

endmodule

bind fenwick_inversion_counter fic_checker u_fic_checker (
  .clk           (clk),
  .rst           (rst),
  .value_valid   (value_valid),
  .value_ready   (value_ready),
  .value         (value),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .smaller_count (smaller_count),
  .running_total (running_total),
  .bad_value     (bad_value)
);

FILE: bench/tb_fenwick_inversion_counter.sv
// ----------------------------------------------------------------------------
// tb_fenwick_inversion_counter
// Streams ranks into the inversion counter and checks every result word
// against a software Fenwick tree kept alongside the block. Directed ranks
// cover the range ends, zero and single-bit patterns; random ranks mix dense
// small ranges with the full 16-bit range. Both sides idle at random, the
// receiver twice stalls long enough to back up the input, and the sender
// drains the block now and then.
// ----------------------------------------------------------------------------
module tb_fenwick_inversion_counter;

  localparam int SIZE           = fic_pkg::SIZE_DEFAULT;
  localparam int RANDOM_ITEMS   = 1430;
  localparam int SETTLE_CYCLES  = 80;
  localparam int LONG_STALL     = 400;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic [fic_pkg::VALUE_W-1:0] rank;
    int unsigned                 gap;
    bit                          drain;
  } rank_item_t;

  typedef struct {
    logic [fic_pkg::COUNT_W-1:0] count;
    logic [fic_pkg::TOTAL_W-1:0] total;
    logic                        bad;
  } inversion_word_t;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        value_valid  = 1'b0;
  logic                        value_ready;
  logic [fic_pkg::VALUE_W-1:0] value        = '0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  logic [fic_pkg::COUNT_W-1:0] smaller_count;
  logic [fic_pkg::TOTAL_W-1:0] running_total;
  logic                        bad_value;

  rank_item_t      pending_ranks[$];
  inversion_word_t expected_words[$];

  logic [fic_pkg::COUNT_W-1:0] node_count[0:SIZE];
  logic [fic_pkg::TOTAL_W-1:0] inversion_sum;

  int unsigned words_in   = 0;
  int unsigned words_out  = 0;
  int unsigned item_total = 0;
  int unsigned errors     = 0;
  int unsigned bad_seen   = 0;
  int unsigned send_wait  = 0;
  int unsigned rcv_wait   = 0;
  int unsigned stall_left = 0;
  int unsigned idle_count = 0;
  logic [fic_pkg::COUNT_W-1:0] peak_count = '0;

  fenwick_inversion_counter #(
    .SIZE(SIZE)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .value_valid  (value_valid),
    .value_ready  (value_ready),
    .value        (value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .smaller_count(smaller_count),
    .running_total(running_total),
    .bad_value    (bad_value)
  );

  always #5 clk = ~clk;

  // prefix query then insert, both saturating
  function automatic inversion_word_t rank_and_insert(
      input logic [fic_pkg::VALUE_W-1:0] rank);
    inversion_word_t w;
    int unsigned     pos;
    logic [63:0]     acc;
    logic [63:0]     sum;
    w.bad   = 1'b0;
    w.count = '0;
    if (rank == 0 || rank > SIZE) begin
      w.bad   = 1'b1;
      w.total = inversion_sum;
      return w;
    end
    acc = '0;
    pos = rank;
    while (pos > 0) begin
      acc += node_count[pos];
      pos -= pos & (~pos + 1);
    end
    w.count = (acc > fic_pkg::COUNT_MAX) ? fic_pkg::COUNT_MAX
                                         : acc[fic_pkg::COUNT_W-1:0];
    pos = rank;
    while (pos > 0 && pos <= SIZE) begin
      if (node_count[pos] != fic_pkg::COUNT_MAX)
        node_count[pos] = node_count[pos] + 1;
      pos += pos & (~pos + 1);
    end
    sum = {16'd0, inversion_sum} + {32'd0, w.count};
    inversion_sum = (sum > fic_pkg::TOTAL_MAX) ? fic_pkg::TOTAL_MAX
                                               : sum[fic_pkg::TOTAL_W-1:0];
    w.total = inversion_sum;
    return w;
  endfunction

  function automatic void add_rank(input logic [fic_pkg::VALUE_W-1:0] rank,
                                   input int unsigned gap, input bit drain);
    rank_item_t it;
    it.rank  = rank;
    it.gap   = gap;
    it.drain = drain;
    pending_ranks = {pending_ranks, it};
    item_total++;
  endfunction

  // driver
  always @(posedge clk) begin : drive_proc
    logic       took;
    logic       offer;
    rank_item_t it;
    if (rst) begin
      value_valid <= 1'b0;
      send_wait = 0;
    end else begin
      took  = value_valid && value_ready;
      offer = value_valid && !took;
      if (took) begin
        expected_words = {expected_words, rank_and_insert(value)};
        words_in <= words_in + 1;
        send_wait = (pending_ranks.size() > 0) ? pending_ranks[0].gap : 0;
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_ranks.size() > 0 &&
                     (!pending_ranks[0].drain || (!took && words_in == words_out))) begin
          it = pending_ranks.pop_front();
          value <= it.rank;
          offer = 1'b1;
        end
      end
      value_valid <= offer;
    end
  end

  // monitor
  always @(posedge clk) begin : collect_proc
    inversion_word_t want;
    if (rst) begin
      result_ready <= 1'b0;
      rcv_wait   = 0;
      stall_left = 0;
    end else begin
      if (result_valid && result_ready) begin
        words_out <= words_out + 1;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: count=%0d total=%0d bad=%0b",
                     smaller_count, running_total, bad_value);
        end else begin
          want = expected_words.pop_front();
          if (want.count !== smaller_count || want.total !== running_total ||
              want.bad !== bad_value) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on word %0d: exp count=%0d total=%0d bad=%0b",
                       words_out, want.count, want.total, want.bad);
              $display("  got count=%0d total=%0d bad=%0b",
                       smaller_count, running_total, bad_value);
            end
          end
        end
        if (bad_value === 1'b1)
          bad_seen++;
        if (smaller_count > peak_count)
          peak_count <= smaller_count;
        if (words_out + 1 == 250 || words_out + 1 == 1000)
          stall_left = LONG_STALL;
        rcv_wait = ((words_out % 300) < 60) ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (rcv_wait > 0) begin
        rcv_wait--;
      end
      result_ready <= (stall_left == 0 && rcv_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (value_valid && value_ready) || (result_valid && result_ready)) begin
      idle_count <= 0;
    end else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin : stimulus
    logic [fic_pkg::VALUE_W-1:0] rank;
    int unsigned                 gap;
    for (int i = 0; i <= SIZE; i++)
      node_count[i] = '0;
    inversion_sum = '0;

    add_rank(16'd1, 0, 1'b0);
    add_rank(16'hFFFF, 0, 1'b0);
    add_rank(16'd0, 3, 1'b0);
    add_rank(16'd1, 0, 1'b0);
    add_rank(16'hFFFF, 0, 1'b0);
    add_rank(16'h8000, 1, 1'b0);
    add_rank(16'h7FFF, 0, 1'b0);
    add_rank(16'h5555, 0, 1'b0);
    add_rank(16'hAAAA, 2, 1'b0);
    add_rank(16'h8001, 0, 1'b0);
    add_rank(16'hFFFE, 0, 1'b0);
    add_rank(16'd2, 0, 1'b0);
    add_rank(16'd2, 0, 1'b0);
    add_rank(16'd3, 0, 1'b0);
    add_rank(16'd0, 0, 1'b0);
    add_rank(16'd16, 0, 1'b0);
    add_rank(16'd15, 0, 1'b0);
    add_rank(16'd17, 0, 1'b0);
    add_rank(16'd255, 0, 1'b0);
    add_rank(16'd256, 0, 1'b0);
    add_rank(16'd4096, 0, 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 19))
        0, 1:              rank = '0;
        2, 3, 4, 5, 6:     rank = fic_pkg::VALUE_W'($urandom_range(0, 65535));
        7, 8, 9:           rank = fic_pkg::VALUE_W'($urandom_range(1, 1024));
        10:                rank = fic_pkg::VALUE_W'($urandom_range(65500, 65535));
        default:           rank = fic_pkg::VALUE_W'($urandom_range(1, 64));
      endcase
      gap = ((i % 200) < 40) ? 0 : $urandom_range(0, 9);
      add_rank(rank, gap, (i % 180) == 179);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (words_in != item_total || words_out != item_total)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_words.size() != 0) begin
      errors += expected_words.size();
      $display("%0d expected words never arrived", expected_words.size());
    end

    $display("checked %0d words, %0d flagged as bad ranks, largest count %0d",
             words_out, bad_seen, peak_count);
    $display("final inversion total %0d, with idle gaps, long output stall and drains",
             inversion_sum);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
